/* rtl/core/pfld_pkg.sv */
// ----------------------------------------------------------------------------
// pfld_pkg
// shared types and constants for the page framebuffer line drawer
// ----------------------------------------------------------------------------
`default_nettype none

package pfld_pkg;

  localparam int SCREEN_WIDTH_DEF = 84;
  localparam int SCREEN_PAGES_DEF = 6;

  localparam logic [1:0] OP_PLOT = 2'd0;
  localparam logic [1:0] OP_LINE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_BYTE_RD,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/page_framebuffer_line_draw.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_line_draw
// monochrome page framebuffer with pixel plot, line draw and byte readback
// ----------------------------------------------------------------------------
// After reset the block sweeps the framebuffer to zero, one byte a cycle, and
// stalls input until all SCREEN_WIDTH*SCREEN_PAGES bytes are cleared.
// Each pixel costs a read-modify-write (a read state, then a write state) on
// the single framebuffer memory, and that port sets the rate: a plot does one
// such pixel, a line max(|dx|,|dy|)+1 of them, a byte read one read; each ends
// in a done state that loads the result. One item is in flight at a time; the
// result register lets the next item start while a finished result waits.
`default_nettype none

module page_framebuffer_line_draw #(
  parameter int SCREEN_WIDTH = pfld_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_PAGES = pfld_pkg::SCREEN_PAGES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] operation,
  input  wire logic [6:0] x_start,
  input  wire logic [5:0] y_start,
  input  wire logic [6:0] x_end,
  input  wire logic [5:0] y_end,
  input  wire logic       set_pixels,
  input  wire logic [8:0] byte_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      read_data,
  output logic [7:0]      pixels_touched
);

  localparam int DEPTH     = SCREEN_WIDTH * SCREEN_PAGES;
  localparam int ROWS      = SCREEN_PAGES * 8;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int IDX_CMP_W = (ADDR_W + 1 > 9) ? ADDR_W + 1 : 9;

  // framebuffer memory
  logic [7:0]        mem [DEPTH];
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [7:0]        rd_data;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [7:0]        mem_wr_data;

  pfld_pkg::state_t state, state_next;

  logic [ADDR_W-1:0] clear_addr;
  logic [6:0]        cur_x;
  logic [5:0]        cur_y;
  logic              xneg;
  logic              yneg;
  logic              x_major;
  logic [6:0]        major;
  logic [6:0]        minor;
  logic [6:0]        acc;
  logic [6:0]        remaining;
  logic [7:0]        count;
  logic [1:0]        op_r;
  logic [ADDR_W-1:0] idx_r;
  logic              idx_ok;
  logic              set_r;
  logic              out_load;

  logic              in_acc;
  logic              acc_xneg;
  logic              acc_yneg;
  logic [6:0]        mdx;
  logic [6:0]        mdy;
  logic [IDX_CMP_W-1:0] idx_ext;

  logic              pix_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0]        pix_bit;
  logic [7:0]        acc_sum;
  logic              carry;
  logic [6:0]        x_step;
  logic [5:0]        y_step;

  assign in_stall = (state != pfld_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // line set-up from the incoming beat
  assign acc_xneg = x_end < x_start;
  assign acc_yneg = y_end < y_start;
  assign mdx      = acc_xneg ? x_start - x_end : x_end - x_start;
  assign mdy      = {1'b0, (acc_yneg ? y_start - y_end : y_end - y_start)};
  assign idx_ext  = IDX_CMP_W'(byte_index);

  // current pixel
  assign pix_ok   = ({1'b0, cur_x} < 8'(SCREEN_WIDTH)) && ({1'b0, cur_y} < 7'(ROWS));
  assign pix_addr = ADDR_W'(32'(cur_y[5:3]) * 32'(SCREEN_WIDTH) + 32'(cur_x));
  assign pix_bit  = 8'(1) << cur_y[2:0];

  // incremental floor(minor*i/major): remainder stays below major
  assign acc_sum  = {1'b0, acc} + {1'b0, minor};
  assign carry    = acc_sum >= {1'b0, major};
  assign x_step   = xneg ? cur_x - 7'd1 : cur_x + 7'd1;
  assign y_step   = yneg ? cur_y - 6'd1 : cur_y + 6'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pfld_pkg::ST_CLEAR: begin
        if (clear_addr == ADDR_W'(DEPTH - 1)) state_next = pfld_pkg::ST_IDLE;
      end
      pfld_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (operation == pfld_pkg::OP_PLOT || operation == pfld_pkg::OP_LINE) begin
            state_next = pfld_pkg::ST_PIX_RD;
          end else if (operation == pfld_pkg::OP_READ) begin
            state_next = pfld_pkg::ST_BYTE_RD;
          end else begin
            state_next = pfld_pkg::ST_DONE;
          end
        end
      end
      pfld_pkg::ST_PIX_RD:  state_next = pfld_pkg::ST_PIX_WR;
      pfld_pkg::ST_PIX_WR: begin
        state_next = (remaining == 7'd0) ? pfld_pkg::ST_DONE : pfld_pkg::ST_PIX_RD;
      end
      pfld_pkg::ST_BYTE_RD: state_next = pfld_pkg::ST_DONE;
      pfld_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = pfld_pkg::ST_IDLE;
      end
      default: state_next = pfld_pkg::ST_CLEAR;
    endcase
  end

  // memory controls and result load
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = pix_addr;
    mem_wr_en   = 1'b0;
    mem_wr_addr = pix_addr;
    mem_wr_data = set_r ? (rd_data | pix_bit) : (rd_data & ~pix_bit);
    out_load    = 1'b0;
    case (state)
      pfld_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clear_addr;
        mem_wr_data = 8'd0;
      end
      pfld_pkg::ST_PIX_RD:  mem_rd_en = pix_ok;
      pfld_pkg::ST_PIX_WR:  mem_wr_en = pix_ok;
      pfld_pkg::ST_BYTE_RD: begin
        mem_rd_en   = idx_ok;
        mem_rd_addr = idx_r;
      end
      pfld_pkg::ST_DONE:    out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) mem[mem_wr_addr] <= mem_wr_data;
    if (mem_rd_en) rd_data <= mem[mem_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pfld_pkg::ST_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pfld_pkg::ST_CLEAR) clear_addr <= clear_addr + ADDR_W'(1);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= operation;
      set_r   <= set_pixels;
      idx_r   <= ADDR_W'(idx_ext);
      idx_ok  <= idx_ext < IDX_CMP_W'(DEPTH);
      cur_x   <= x_start;
      cur_y   <= y_start;
      xneg    <= acc_xneg;
      yneg    <= acc_yneg;
      x_major <= mdx >= mdy;
      major   <= (mdx >= mdy) ? mdx : mdy;
      minor   <= (mdx >= mdy) ? mdy : mdx;
      acc     <= 7'd0;
      count   <= 8'd0;
      if (operation == pfld_pkg::OP_LINE) begin
        remaining <= (mdx >= mdy) ? mdx : mdy;
      end else begin
        remaining <= 7'd0;
      end
    end else if (state == pfld_pkg::ST_PIX_WR) begin
      if (pix_ok) count <= count + 8'd1;
      if (remaining != 7'd0) begin
        remaining <= remaining - 7'd1;
        acc       <= carry ? 7'(acc_sum - {1'b0, major}) : acc_sum[6:0];
        if (x_major) begin
          cur_x <= x_step;
          if (carry) cur_y <= y_step;
        end else begin
          cur_y <= y_step;
          if (carry) cur_x <= x_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data      <= (op_r == pfld_pkg::OP_READ && idx_ok) ? rd_data : 8'd0;
      pixels_touched <= count;
    end
  end

endmodule

`default_nettype wire
